// ----- src/assert_macros.svh -----
// assertion macros used by sparse_polynomial_add
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock outside reset
`define AST_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define AST_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/spa_pkg.sv -----
// shared types and codes for the sparse polynomial adder
package spa_pkg;

  localparam int COEFF_W = 32;
  localparam int EXP_W   = 16;
  localparam int TERM_W  = COEFF_W + EXP_W;

  typedef enum logic [1:0] {
    OP_APPEND_A = 2'd0,
    OP_APPEND_B = 2'd1,
    OP_MERGE    = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  // coefficient sits in the low bits, exponent above it
  typedef struct packed {
    logic [EXP_W-1:0]   exponent;
    logic [COEFF_W-1:0] coeff;
  } term_t;

  localparam logic [COEFF_W-1:0] COEFF_MAX = {1'b0, {(COEFF_W-1){1'b1}}};
  localparam logic [COEFF_W-1:0] COEFF_MIN = {1'b1, {(COEFF_W-1){1'b0}}};

endpackage

// ----- src/sparse_polynomial_add.sv -----
// sparse polynomial adder: two term lists in ram, merged on request
// Input words: tuser carries the op (append to A, append to B, merge);
// tdata carries coeff and exponent for appends and is ignored on merge.
// Appends write the next free entry of their list and give no output;
// an append to a full list, and the unused op code, are dropped.
// Appends are taken one per cycle while no merge is running.
// A merge starts the walk from the heads of both lists, then emits one
// term per cycle while the output is not stalled; each compare selects
// the next read addresses of both lists.
// An empty merge gives a single word flagged is_empty.
// Output words carry sum_coeff and sum_exponent in tdata, is_empty in
// tuser; tlast marks the final term. Both counts clear with that term.
// s_tready is low for the length of a merge walk.
// A stalled receiver holds the output register; the walk pauses and
// re-reads the same entries until the register frees up. The next input
// word is still taken while a finished result waits.
// Reset clears counts, the sequencer and the output valid; list
// contents stay undefined until written.
`include "assert_macros.svh"

module sparse_polynomial_add
  import spa_pkg::*;
#(
  parameter int MAX_TERMS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // coeff[31:0], exponent[47:32]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // sum_coeff[31:0], sum_exponent[47:32]
  output logic [0:0]  m_tuser,   // is_empty[0]
  output logic        m_tlast
);

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TERMS);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MERGE = 2'b10
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] cnt_a, cnt_b;
  logic [CW-1:0] idx_a, idx_b, idx_a_next, idx_b_next;

  logic          in_acc;
  op_t           in_op;
  logic          we_a, we_b;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [TERM_W-1:0] rdata_a, rdata_b;
  term_t         term_a, term_b, term_out;

  logic          out_free, emit, avail_a, avail_b, take_a, take_b, both_empty, walk_done;
  logic [COEFF_W:0] wide_sum;
  logic [COEFF_W-1:0] sat_sum;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign in_op    = op_t'(s_tuser);
  assign we_a     = in_acc && (in_op == OP_APPEND_A) && (cnt_a < CNT_MAX);
  assign we_b     = in_acc && (in_op == OP_APPEND_B) && (cnt_b < CNT_MAX);

  spa_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a[AW-1:0]),
    .wdata (s_tdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  spa_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b[AW-1:0]),
    .wdata (s_tdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  assign term_a = term_t'(rdata_a);
  assign term_b = term_t'(rdata_b);

  // merge step on the entries read for the current indexes
  assign out_free   = !m_tvalid || m_tready;
  assign emit       = (state == ST_MERGE) && out_free;
  assign avail_a    = idx_a < cnt_a;
  assign avail_b    = idx_b < cnt_b;
  assign both_empty = (cnt_a == '0) && (cnt_b == '0);

  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    if (avail_a && avail_b) begin
      if (term_a.exponent == term_b.exponent) begin
        take_a = 1'b1;
        take_b = 1'b1;
      end else if (term_a.exponent > term_b.exponent) begin
        take_a = 1'b1;
      end else begin
        take_b = 1'b1;
      end
    end else if (avail_a) begin
      take_a = 1'b1;
    end else if (avail_b) begin
      take_b = 1'b1;
    end
  end

  assign wide_sum = {term_a.coeff[COEFF_W-1], term_a.coeff}
                  + {term_b.coeff[COEFF_W-1], term_b.coeff};

  always_comb begin
    if (wide_sum[COEFF_W] != wide_sum[COEFF_W-1]) begin
      sat_sum = wide_sum[COEFF_W] ? COEFF_MIN : COEFF_MAX;
    end else begin
      sat_sum = wide_sum[COEFF_W-1:0];
    end
  end

  always_comb begin
    if (take_a && take_b) begin
      term_out.coeff    = sat_sum;
      term_out.exponent = term_a.exponent;
    end else if (take_a) begin
      term_out = term_a;
    end else begin
      term_out = term_b;
    end
  end

  assign idx_a_next = idx_a + CW'(take_a);
  assign idx_b_next = idx_b + CW'(take_b);
  assign walk_done  = (idx_a_next == cnt_a) && (idx_b_next == cnt_b);

  // hold the read addresses while the output is stalled
  always_comb begin
    if (state == ST_IDLE) begin
      raddr_a = '0;
      raddr_b = '0;
    end else if (emit) begin
      raddr_a = idx_a_next[AW-1:0];
      raddr_b = idx_b_next[AW-1:0];
    end else begin
      raddr_a = idx_a[AW-1:0];
      raddr_b = idx_b[AW-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && (in_op == OP_MERGE)) begin
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (emit && (both_empty || walk_done)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt_a    <= '0;
      cnt_b    <= '0;
      idx_a    <= '0;
      idx_b    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (we_a) begin
        cnt_a <= cnt_a + CW'(1);
      end
      if (we_b) begin
        cnt_b <= cnt_b + CW'(1);
      end
      if (state == ST_IDLE) begin
        idx_a <= '0;
        idx_b <= '0;
      end else if (emit) begin
        idx_a <= idx_a_next;
        idx_b <= idx_b_next;
        if (both_empty || walk_done) begin
          cnt_a <= '0;
          cnt_b <= '0;
        end
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (both_empty) begin
        m_tdata    <= '0;
        m_tuser[0] <= 1'b1;
        m_tlast    <= 1'b1;
      end else begin
        m_tdata    <= term_out;
        m_tuser[0] <= 1'b0;
        m_tlast    <= walk_done;
      end
    end
  end

  `AST_ALWAYS(a_cnt_range, (cnt_a <= CNT_MAX) && (cnt_b <= CNT_MAX), "count beyond capacity")
  `AST_IMPLY(a_idx_range, state == ST_MERGE, (idx_a <= cnt_a) && (idx_b <= cnt_b), "index past count")
  `AST_NEXT(a_done_clear, emit && (both_empty || walk_done), (state == ST_IDLE) && (cnt_a == '0) && (cnt_b == '0) && m_tvalid && m_tlast, "merge end did not clear")
  `AST_IMPLY(a_empty_last, m_tvalid && m_tuser[0], m_tlast, "empty word not marked last")

endmodule

// ----- src/spa_ram.sv -----
// generic single-port-write ram with registered read
module spa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
